FILE: hdl/dll_pkg.sv
// Shared command and status codes and field widths for the linked-list manager.
package dll_pkg;

    localparam int CMD_W    = 3;
    localparam int NODE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 9;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RM_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PUSH_DUP   = 2'd3;

endpackage

FILE: hdl/dll_link_ram.sv
// Simple dual-port synchronous RAM for node links, registered read.
module dll_link_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 9
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/doubly_linked_list_manager.sv
// Top level of the doubly linked list deque manager over a pool of node indices.
//
//  Channel  | Dir | Signals                       | Contents (lowest bit first)
//  ---------+-----+-------------------------------+--------------------------------------
//  s_axis   | in  | s_tvalid s_tready s_tdata[16] | command[2:0], node[10:3]
//  m_axis   | out | m_tvalid m_tready m_tdata[24] | result_node[7:0], list_size[16:8]
//           |     | m_tuser[3]                    | result_valid[0], status[2:1]
//
// Push commands, rejected commands, unused codes and pops on an empty list
// finish in the cycle of the transfer. Pop and remove of a member pass through
// ST_UNLINK: the link RAMs are read at the node, then both neighbors are patched.
// A new command is taken while idle once the result register is empty or draining.
// rst_n clears head, tail, count, membership flags and control; link RAMs
// need no clearing since a link is always written before it is used.
module doubly_linked_list_manager #(
    parameter int NODE_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command[2:0], node[10:3], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // result_node[7:0], list_size[16:8], zero pad
    output logic [2:0]  m_tuser    // result_valid[0], status[2:1]
);
    import dll_pkg::*;

    // Only indices reachable by the 8-bit node field can ever join the list.
    localparam int POOL = (NODE_COUNT < (1 << NODE_W)) ? NODE_COUNT : (1 << NODE_W);
    localparam int AW   = $clog2(POOL);
    localparam int LW   = $clog2(NODE_COUNT + 1);   // link holds index or none
    localparam int CW   = $clog2(POOL + 1);
    localparam logic [LW-1:0]     LINK_NONE = LW'(NODE_COUNT);
    localparam logic [NODE_W:0]   POOL_LIM  = (NODE_W + 1)'(POOL);

    typedef enum logic {ST_IDLE, ST_UNLINK} state_t;

    state_t              state_reg;
    logic [LW-1:0]       head_reg, tail_reg;
    logic [CW-1:0]       count_reg;
    logic [POOL-1:0]     member_reg;
    logic [AW-1:0]       target_reg;
    logic                pop_reg;

    logic                out_valid_reg;
    logic [NODE_W-1:0]   out_node_reg;
    logic                out_rvalid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SIZE_W-1:0]   out_size_reg;

    // Next values
    state_t              state_next;
    logic [LW-1:0]       head_next, tail_next;
    logic [CW-1:0]       count_next;
    logic [POOL-1:0]     member_next;
    logic [AW-1:0]       target_next;
    logic                pop_next;
    logic                out_valid_next;
    logic [NODE_W-1:0]   out_node_next;
    logic                out_rvalid_next;
    logic [STATUS_W-1:0] out_status_next;
    logic [SIZE_W-1:0]   out_size_next;

    // Link RAM ports
    logic                nx_wr_en, pv_wr_en, rd_en;
    logic [AW-1:0]       nx_wr_addr, pv_wr_addr, rd_addr;
    logic [LW-1:0]       nx_wr_data, pv_wr_data, nx_rd_data, pv_rd_data;

    // Decoded input
    logic [CMD_W-1:0]    cmd;
    logic [NODE_W-1:0]   node_in;
    logic [AW-1:0]       node_addr;
    logic                node_ok;
    logic                accept;
    logic [LW-1:0]       unl_nx, unl_pv;

    assign cmd       = s_tdata[CMD_W-1:0];
    assign node_in   = s_tdata[CMD_W +: NODE_W];
    assign node_addr = node_in[AW-1:0];
    assign node_ok   = ({1'b0, node_in} < POOL_LIM);
    assign s_tready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;

    // Head never uses its prev link, tail never its next link.
    assign unl_nx = (LW'(target_reg) == tail_reg) ? LINK_NONE : nx_rd_data;
    assign unl_pv = (LW'(target_reg) == head_reg) ? LINK_NONE : pv_rd_data;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        member_next     = member_reg;
        target_next     = target_reg;
        pop_next        = pop_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_node_next   = out_node_reg;
        out_rvalid_next = out_rvalid_reg;
        out_status_next = out_status_reg;
        out_size_next   = out_size_reg;
        nx_wr_en        = 1'b0;
        nx_wr_addr      = node_addr;
        nx_wr_data      = head_reg;
        pv_wr_en        = 1'b0;
        pv_wr_addr      = node_addr;
        pv_wr_data      = tail_reg;
        rd_en           = 1'b0;
        rd_addr         = node_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // default: a result this cycle
                    out_valid_next  = 1'b1;
                    out_node_next   = '0;
                    out_rvalid_next = 1'b0;
                    out_status_next = ST_DONE;
                    out_size_next   = SIZE_W'(count_reg);
                    case (cmd)
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            if (!node_ok || member_reg[node_addr])
                            begin
                                out_status_next = ST_PUSH_DUP;
                            end
                            else
                            begin
                                member_next[node_addr] = 1'b1;
                                count_next    = count_reg + 1'b1;
                                out_size_next = SIZE_W'(count_reg + 1'b1);
                                if (cmd == CMD_PUSH_FRONT)
                                begin
                                    nx_wr_en   = 1'b1;           // next[n] = head
                                    nx_wr_data = head_reg;
                                    pv_wr_en   = (head_reg != LINK_NONE);
                                    pv_wr_addr = head_reg[AW-1:0];
                                    pv_wr_data = LW'(node_addr);
                                    head_next  = LW'(node_addr);
                                    if (tail_reg == LINK_NONE)
                                    begin
                                        tail_next = LW'(node_addr);
                                    end
                                end
                                else
                                begin
                                    pv_wr_en   = 1'b1;           // prev[n] = tail
                                    pv_wr_data = tail_reg;
                                    nx_wr_en   = (tail_reg != LINK_NONE);
                                    nx_wr_addr = tail_reg[AW-1:0];
                                    nx_wr_data = LW'(node_addr);
                                    tail_next  = LW'(node_addr);
                                    if (head_reg == LINK_NONE)
                                    begin
                                        head_next = LW'(node_addr);
                                    end
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            if (head_reg == LINK_NONE)
                            begin
                                out_status_next = ST_POP_EMPTY;
                            end
                            else
                            begin
                                target_next = (cmd == CMD_POP_FRONT) ?
                                              head_reg[AW-1:0] : tail_reg[AW-1:0];
                                rd_en          = 1'b1;
                                rd_addr        = target_next;
                                pop_next       = 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = ST_UNLINK;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!node_ok || !member_reg[node_addr])
                            begin
                                out_status_next = ST_RM_MISSING;
                            end
                            else
                            begin
                                target_next    = node_addr;
                                rd_en          = 1'b1;
                                rd_addr        = node_addr;
                                pop_next       = 1'b0;
                                out_valid_next = 1'b0;
                                state_next     = ST_UNLINK;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_DONE;   // unused codes: no change
                        end
                    endcase
                end
            end
            ST_UNLINK:
            begin
                // links of the target are now on the RAM read ports
                if (LW'(target_reg) == head_reg)
                begin
                    head_next = unl_nx;
                end
                else
                begin
                    nx_wr_en   = 1'b1;
                    nx_wr_addr = unl_pv[AW-1:0];
                    nx_wr_data = unl_nx;
                end
                if (LW'(target_reg) == tail_reg)
                begin
                    tail_next = unl_pv;
                end
                else
                begin
                    pv_wr_en   = 1'b1;
                    pv_wr_addr = unl_nx[AW-1:0];
                    pv_wr_data = unl_pv;
                end
                member_next[target_reg] = 1'b0;
                count_next      = count_reg - 1'b1;
                out_valid_next  = 1'b1;
                out_node_next   = pop_reg ? NODE_W'(target_reg) : '0;
                out_rvalid_next = pop_reg;
                out_status_next = ST_DONE;
                out_size_next   = SIZE_W'(count_reg - 1'b1);
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= LINK_NONE;
            tail_reg       <= LINK_NONE;
            count_reg      <= '0;
            member_reg     <= '0;
            target_reg     <= '0;
            pop_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_node_reg   <= '0;
            out_rvalid_reg <= 1'b0;
            out_status_reg <= ST_DONE;
            out_size_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            member_reg     <= member_next;
            target_reg     <= target_next;
            pop_reg        <= pop_next;
            out_valid_reg  <= out_valid_next;
            out_node_reg   <= out_node_next;
            out_rvalid_reg <= out_rvalid_next;
            out_status_reg <= out_status_next;
            out_size_reg   <= out_size_next;
        end
    end

    dll_link_ram #(.DEPTH(POOL), .WIDTH(LW)) u_next_ram (
        .clk     (clk),
        .wr_en   (nx_wr_en),
        .wr_addr (nx_wr_addr),
        .wr_data (nx_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (nx_rd_data)
    );

    dll_link_ram #(.DEPTH(POOL), .WIDTH(LW)) u_prev_ram (
        .clk     (clk),
        .wr_en   (pv_wr_en),
        .wr_addr (pv_wr_addr),
        .wr_data (pv_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (pv_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_size_reg, out_node_reg};
    assign m_tuser  = {out_status_reg, out_rvalid_reg};

`ifndef SYNTHESIS
    // empty list has neither head nor tail, and a nonempty one has both
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == LINK_NONE) == (count_reg == '0))
        else $error("head and count disagree");
    a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg == LINK_NONE) == (head_reg == LINK_NONE))
        else $error("head and tail disagree on empty");
    // membership flags track the count
    a_member_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(member_reg) == int'(count_reg))
        else $error("member flags do not match count");
    // unlink is always followed by idle with a result in the next cycle
    a_unlink_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UNLINK) |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("unlink did not complete");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the doubly linked list manager: stream driver, monitor, predictor.
module testbench;

    import dll_pkg::*;

    // Spare command codes; the block treats them as no-ops.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam int              POOL_SIZE  = 256;
    localparam logic [SIZE_W-1:0] NO_NODE  = 9'd256;  // "none" link value
    localparam int              IDLE_LIMIT = 2000;    // cycles without any transfer
    localparam int              HOLD_LEN   = 300;     // long receiver hold-off
    localparam int              TAIL_WAIT  = 20;      // cycles after the last result

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [NODE_W-1:0] node;
        bit                drain;   // wait for all results before offering
    } dll_cmd_t;

    typedef struct {
        logic [NODE_W-1:0]   node;
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   size;
    } dll_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // command[2:0], node[10:3], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // result_node[7:0], list_size[16:8], zero pad
    logic [2:0]  m_tuser;         // result_valid[0], status[2:1]

    doubly_linked_list_manager dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the list.
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] link_next [POOL_SIZE];
    logic [SIZE_W-1:0] link_prev [POOL_SIZE];
    bit                in_list   [POOL_SIZE];
    logic [SIZE_W-1:0] list_head = NO_NODE;
    logic [SIZE_W-1:0] list_tail = NO_NODE;
    logic [SIZE_W-1:0] list_count = '0;

    dll_cmd_t    cmd_queue[$];        // commands waiting to be driven
    dll_result_t pending_results[$];  // expected results in order

    int cmds_sent     = 0;   // updated at the edge, read with pre-edge value
    int results_seen  = 0;
    int mismatch_count = 0;

    // Generation-time view of the list order, used only to pick members.
    int plan_order[$];
    bit plan_member [POOL_SIZE];

    // Unlink a member node and patch its neighbors.
    function automatic void drop_node(logic [NODE_W-1:0] n);
        logic [SIZE_W-1:0] nx;
        logic [SIZE_W-1:0] pv;
        nx = link_next[n];
        pv = link_prev[n];
        if ({1'b0, n} == list_head)
            list_head = nx;
        else
            link_next[pv[NODE_W-1:0]] = nx;
        if ({1'b0, n} == list_tail)
            list_tail = pv;
        else
            link_prev[nx[NODE_W-1:0]] = pv;
        in_list[n] = 1'b0;
        list_count = list_count - 1'b1;
    endfunction

    // Apply one command to the predictor and return the result it yields.
    function automatic dll_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                  logic [NODE_W-1:0] n);
        dll_result_t       res;
        logic [SIZE_W-1:0] tip;
        res.node   = '0;
        res.valid  = 1'b0;
        res.status = ST_DONE;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (in_list[n])
                    res.status = ST_PUSH_DUP;
                else
                begin
                    if (cmd == CMD_PUSH_FRONT)
                    begin
                        link_next[n] = list_head;
                        link_prev[n] = NO_NODE;
                        if (list_tail == NO_NODE)
                            list_tail = {1'b0, n};
                        else
                            link_prev[list_head[NODE_W-1:0]] = {1'b0, n};
                        list_head = {1'b0, n};
                    end
                    else
                    begin
                        link_next[n] = NO_NODE;
                        link_prev[n] = list_tail;
                        if (list_head == NO_NODE)
                            list_head = {1'b0, n};
                        else
                            link_next[list_tail[NODE_W-1:0]] = {1'b0, n};
                        list_tail = {1'b0, n};
                    end
                    in_list[n] = 1'b1;
                    list_count = list_count + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                tip = (cmd == CMD_POP_FRONT) ? list_head : list_tail;
                if (tip == NO_NODE || list_count == 0)
                    res.status = ST_POP_EMPTY;
                else
                begin
                    drop_node(tip[NODE_W-1:0]);
                    res.node  = tip[NODE_W-1:0];
                    res.valid = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (!in_list[n] || list_count == 0)
                    res.status = ST_RM_MISSING;
                else
                    drop_node(n);
            end
            default: ;  // spare codes change nothing
        endcase
        res.size = list_count;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < 40)
            $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Queue a command and keep the generation view of the list in step.
    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] n, bit drain);
        dll_cmd_t c;
        int       v;
        c.cmd   = cmd;
        c.node  = n;
        c.drain = drain;
        cmd_queue.insert(cmd_queue.size(), c);
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
                if (!plan_member[n])
                begin
                    plan_member[n] = 1'b1;
                    if (cmd == CMD_PUSH_FRONT)
                        plan_order.insert(0, int'(n));
                    else
                        plan_order.insert(plan_order.size(), int'(n));
                end
            CMD_POP_FRONT, CMD_POP_BACK:
                if (plan_order.size() > 0)
                begin
                    if (cmd == CMD_POP_FRONT)
                    begin
                        v = plan_order[0];
                        plan_order.delete(0);
                    end
                    else
                    begin
                        v = plan_order[plan_order.size() - 1];
                        plan_order.delete(plan_order.size() - 1);
                    end
                    plan_member[v] = 1'b0;
                end
            CMD_REMOVE:
                if (plan_member[n])
                begin
                    plan_member[n] = 1'b0;
                    foreach (plan_order[i])
                        if (plan_order[i] == n)
                        begin
                            plan_order.delete(i);
                            break;
                        end
                end
            default: ;
        endcase
    endtask

    function automatic logic [NODE_W-1:0] pick_member();
        if (plan_order.size() == 0)
            return NODE_W'($urandom_range(0, POOL_SIZE - 1));
        return NODE_W'(plan_order[$urandom_range(0, plan_order.size() - 1)]);
    endfunction

    // Random mix with random content; pushes dominate so the list grows.
    task automatic queue_random_mix(int count, bit drain_first);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 28)
                queue_cmd(CMD_PUSH_FRONT, NODE_W'($urandom_range(0, 255)),
                          drain_first && i == 0);
            else if (r < 56)
                queue_cmd(CMD_PUSH_BACK, NODE_W'($urandom_range(0, 255)),
                          drain_first && i == 0);
            else if (r < 68)
                queue_cmd(CMD_POP_FRONT, NODE_W'($urandom_range(0, 255)),
                          drain_first && i == 0);
            else if (r < 80)
                queue_cmd(CMD_POP_BACK, NODE_W'($urandom_range(0, 255)),
                          drain_first && i == 0);
            else if (r < 92)
                queue_cmd(CMD_REMOVE, pick_member(), drain_first && i == 0);
            else if (r < 97)
                queue_cmd(CMD_REMOVE, NODE_W'($urandom_range(0, 255)),
                          drain_first && i == 0);
            else
                queue_cmd(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                          NODE_W'($urandom_range(0, 255)), drain_first && i == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued commands with a random gap before each one.
    // ------------------------------------------------------------------
    int s_wait  = 0;
    bit s_quiet = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : driver
        bit          vld;
        int          sent;
        dll_cmd_t    c;
        dll_result_t want;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            vld  = s_tvalid;
            sent = cmds_sent;
            if (s_tvalid && s_tready)
            begin
                // transfer accepted: predict its result now
                want = apply_command(s_tdata[2:0], s_tdata[10:3]);
                pending_results.insert(pending_results.size(), want);
                sent = cmds_sent + 1;
                cmds_sent <= sent;
                vld = 1'b0;
                if ($urandom_range(0, 29) == 0)
                    s_quiet = !s_quiet;
                s_wait = s_quiet ? 0 : $urandom_range(0, 10);
            end
            if (!vld)
            begin
                if (s_wait != 0)
                    s_wait--;
                else if (cmd_queue.size() > 0 &&
                         !(cmd_queue[0].drain && sent != results_seen))
                begin
                    c = cmd_queue[0];
                    cmd_queue.delete(0);
                    s_tdata <= {5'b0, c.node, c.cmd};
                    vld = 1'b1;
                end
            end
            s_tvalid <= vld;
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here so the sender keeps pushing
    // and the block backs up into its input.
    // ------------------------------------------------------------------
    int hold_left    = 0;
    int next_hold_at = 100;
    int holds_done   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && results_seen >= next_hold_at)
        begin
            hold_left    <= HOLD_LEN;
            holds_done   <= holds_done + 1;
            next_hold_at <= next_hold_at + 320;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes results, compares each field with the oldest
    // expectation, then waits a random number of cycles.
    // ------------------------------------------------------------------
    int m_wait  = 0;
    bit m_quiet = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : monitor
        bit          rdy;
        dll_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rdy = m_tready;
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending", m_tdata[16:8], 0);
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (m_tdata[7:0] !== want.node)
                        report_mismatch("result_node", m_tdata[7:0], want.node);
                    if (m_tuser[0] !== want.valid)
                        report_mismatch("result_valid", m_tuser[0], want.valid);
                    if (m_tuser[2:1] !== want.status)
                        report_mismatch("status", m_tuser[2:1], want.status);
                    if (m_tdata[16:8] !== want.size)
                        report_mismatch("list_size", m_tdata[16:8], want.size);
                end
                rdy = 1'b0;
                if ($urandom_range(0, 29) == 0)
                    m_quiet = !m_quiet;
                m_wait = m_quiet ? 0 : $urandom_range(0, 10);
            end
            if (!rdy)
            begin
                if (m_wait != 0)
                    m_wait--;
                else
                    rdy = 1'b1;
            end
            if (hold_left != 0)
                rdy = 1'b0;
            m_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer means the block is stuck.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int           pool[$];
        int           k;
        logic [NODE_W-1:0] n;

        foreach (in_list[i])
        begin
            in_list[i]     = 1'b0;
            plan_member[i] = 1'b0;
            link_next[i]   = '0;
            link_prev[i]   = '0;
        end

        // Directed: empty-list corner cases, spare codes, duplicates,
        // removal at head, tail and middle, node field extremes.
        queue_cmd(CMD_POP_FRONT,   8'd0,   1'b0);
        queue_cmd(CMD_POP_BACK,    8'd255, 1'b0);
        queue_cmd(CMD_REMOVE,      8'd0,   1'b0);
        queue_cmd(CMD_SPARE_FIRST, 8'd255, 1'b0);
        queue_cmd(CMD_SPARE_FIRST + 3'd1, 8'd0, 1'b0);
        queue_cmd(CMD_SPARE_LAST,  8'd255, 1'b0);
        queue_cmd(CMD_PUSH_FRONT,  8'd0,   1'b0);
        queue_cmd(CMD_PUSH_BACK,   8'd255, 1'b0);
        queue_cmd(CMD_PUSH_FRONT,  8'd0,   1'b0);   // already a member
        queue_cmd(CMD_PUSH_BACK,   8'd255, 1'b0);   // already a member
        queue_cmd(CMD_PUSH_BACK,   8'd128, 1'b0);
        queue_cmd(CMD_PUSH_FRONT,  8'd1,   1'b0);   // list: 1 0 255 128
        queue_cmd(CMD_REMOVE,      8'd0,   1'b0);   // middle
        queue_cmd(CMD_REMOVE,      8'd128, 1'b0);   // tail
        queue_cmd(CMD_REMOVE,      8'd0,   1'b0);   // no longer a member
        queue_cmd(CMD_REMOVE,      8'd1,   1'b0);   // head
        queue_cmd(CMD_POP_FRONT,   8'd7,   1'b0);   // last node
        queue_cmd(CMD_POP_BACK,    8'd0,   1'b0);   // empty again
        queue_cmd(CMD_PUSH_BACK,   8'd170, 1'b0);
        queue_cmd(CMD_PUSH_FRONT,  8'd85,  1'b0);
        queue_cmd(CMD_POP_BACK,    8'd255, 1'b0);
        queue_cmd(CMD_REMOVE,      8'd85,  1'b0);   // only node

        // Random mix while the list grows and shrinks.
        queue_random_mix(120, 1'b1);

        // Fill the pool completely in random order, then try one more push.
        for (int i = 0; i < POOL_SIZE; i++)
            if (!plan_member[i])
                pool.insert(pool.size(), i);
        k = 0;
        while (pool.size() > 0)
        begin
            int j;
            j = $urandom_range(0, pool.size() - 1);
            n = NODE_W'(pool[j]);
            pool.delete(j);
            queue_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, n, k == 0);
            k++;
        end
        // full list, member
        queue_cmd(CMD_PUSH_BACK, NODE_W'($urandom_range(0, 255)), 1'b0);

        // Empty it again through removes and pops from both ends.
        k = 0;
        while (plan_order.size() > 0)
        begin
            int r;
            r = $urandom_range(0, 9);
            if (r < 4)
                queue_cmd(CMD_REMOVE, pick_member(), k == 0);
            else if (r < 7)
                queue_cmd(CMD_POP_FRONT, NODE_W'($urandom_range(0, 255)), k == 0);
            else
                queue_cmd(CMD_POP_BACK, NODE_W'($urandom_range(0, 255)), k == 0);
            k++;
        end
        queue_cmd(CMD_POP_FRONT, NODE_W'($urandom_range(0, 255)), 1'b0);
        queue_cmd(CMD_REMOVE,    NODE_W'($urandom_range(0, 255)), 1'b0);

        // Final random mix starting from an empty list.
        queue_random_mix(60, 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every command to go out and every result to come back.
        while (cmd_queue.size() > 0 || s_tvalid || cmds_sent != results_seen)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
